@@ sv/polygon_area_perimeter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Polygon area and perimeter core: assertion macros
// Shared concurrent assertion forms for the core and its root unit.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_PERIMETER_CORE_DEFINES_SVH
`define POLYGON_AREA_PERIMETER_CORE_DEFINES_SVH

// same-cycle implication
`define PAP_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pap_pkg.sv @@
// ----------------------------------------------------------------------------
// Polygon area and perimeter package
// Field widths, default parameters and sequencer encodings.
// ----------------------------------------------------------------------------
package pap_pkg;

   localparam int VertexWidth        = 16;
   localparam int AreaWidth          = 43;
   localparam int PerimWidth         = 27;
   localparam int SideWidth          = 11;

   localparam int MaxVerticesDefault = 1024;
   localparam int CoordWidthDefault  = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_ACC,
      ST_DONE
   } pap_state_type;

   typedef enum logic [2:0] {
      MUL_XY,
      MUL_YX,
      MUL_DXX,
      MUL_DYY,
      MUL_FLUSH
   } pap_step_type;

endpackage

@@ sv/pap_if.sv @@
// ----------------------------------------------------------------------------
// Polygon area and perimeter channels
// Valid/ready channels for vertex requests and area/perimeter responses.
// ----------------------------------------------------------------------------
interface pap_req_if import pap_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VertexWidth-1:0] vertex_x;
   logic signed [VertexWidth-1:0] vertex_y;
   logic                          is_last;

   modport source (output valid, output vertex_x, output vertex_y, output is_last,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input is_last,
                   output ready);
endinterface

interface pap_rsp_if import pap_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [AreaWidth-1:0] area;
   logic        [PerimWidth-1:0] perimeter;
   logic        [SideWidth-1:0] side_count;
   logic                        overflow;

   modport source (output valid, output area, output perimeter, output side_count,
                   output overflow, input ready);
   modport sink   (input valid, input area, input perimeter, input side_count,
                   input overflow, output ready);
endinterface

@@ sv/pap_sqrt.sv @@
// ----------------------------------------------------------------------------
// Polygon area and perimeter: integer square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`include "polygon_area_perimeter_core_defines.svh"

module pap_sqrt import pap_pkg::*; #(
   parameter int ROOT_WIDTH = CoordWidthDefault + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*ROOT_WIDTH-1:0]   radicand,
   output logic                      done,
   output logic [ROOT_WIDTH-1:0]     root
);

   localparam int RadWidth  = 2 * ROOT_WIDTH;
   localparam int IterWidth = $clog2(ROOT_WIDTH);
   localparam logic [IterWidth-1:0] LastIter = IterWidth'(ROOT_WIDTH - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [IterWidth-1:0]  iter_ff;
   logic [RadWidth-1:0]   rad_ff;
   logic [ROOT_WIDTH:0]   rem_ff;
   logic [ROOT_WIDTH-1:0] root_ff;

   logic [ROOT_WIDTH+1:0] rem_sh;
   logic [ROOT_WIDTH+1:0] trial;
   logic [ROOT_WIDTH+1:0] diff;
   logic                  ge;
   logic [ROOT_WIDTH:0]   rem_in;
   logic [ROOT_WIDTH-1:0] root_in;
   logic                  launch;

   assign launch = start && !busy_ff;

   always_comb begin
      rem_sh  = {rem_ff[ROOT_WIDTH-1:0], rad_ff[RadWidth-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      diff    = rem_sh - trial;
      rem_in  = ge ? diff[ROOT_WIDTH:0] : rem_sh[ROOT_WIDTH:0];
      root_in = {root_ff[ROOT_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= busy_ff && (iter_ff == LastIter);
         if (launch) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            if (iter_ff == LastIter) begin
               busy_ff <= 1'b0;
            end else begin
               iter_ff <= iter_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RadWidth-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   `PAP_ASSERT_NEXT(a_start_busy, clock, reset, launch, busy_ff, "root unit did not start")
   `PAP_ASSERT(a_done_idle, clock, reset, done_ff, !busy_ff, "root done while still busy")
   `PAP_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "root done held")
   `PAP_ASSERT(a_iter_bound, clock, reset, busy_ff, iter_ff <= LastIter, "root step overrun")

endmodule

@@ sv/polygon_area_perimeter_core.sv @@
// ----------------------------------------------------------------------------
// Polygon area and perimeter core
// Shoelace area and floor-root perimeter of a polygon, one vertex a transfer.
// ----------------------------------------------------------------------------
// Vertices arrive on req_chan as signed Q.4 x and y with is_last on the final
// one. One result per polygon leaves on rsp_chan: signed area in 1/512 units,
// perimeter in 1/16 units, saturating side count and an overflow flag.
// Each edge runs through one shared multiplier (four products) and one
// bit-serial square root unit. A first vertex that is not last is only stored;
// any other vertex runs the edge from the previous vertex before the core takes
// the next one. The last vertex also does the closing edge; the core is ready
// again in the cycle in which its result becomes valid. A polygon of one vertex
// has only the closing edge.
// req_chan.ready is high only while the core is idle.
// Reset clears the sums, the vertex count and the output valid flag.
// The result sits in an output register; a stalled receiver does not block
// new vertices. Only a further result waits until the register is free.
// ----------------------------------------------------------------------------
`include "polygon_area_perimeter_core_defines.svh"

module polygon_area_perimeter_core import pap_pkg::*; #(
   parameter int MAX_VERTICES = MaxVerticesDefault,
   parameter int COORD_WIDTH  = CoordWidthDefault
) (
   input  logic      clock,
   input  logic      reset,
   pap_req_if.sink   req_chan,
   pap_rsp_if.source rsp_chan
);

   localparam int MulWidth   = COORD_WIDTH + 1;
   localparam int ProdWidth  = 2 * MulWidth;
   localparam int SqWidth    = 2 * COORD_WIDTH + 1;
   localparam int AccWidth   = ((ProdWidth > AreaWidth) ? ProdWidth : AreaWidth) + 1;
   localparam int PsumWidth  = ((MulWidth > PerimWidth) ? MulWidth : PerimWidth) + 1;
   localparam int CountWidth = $clog2(MAX_VERTICES + 1);
   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_VERTICES);

   pap_state_type state_ff, state_in;
   pap_step_type  step_ff, step_in;
   pap_step_type  p_step_ff;

   logic                          p_vld_ff, p_vld_in;
   logic signed [ProdWidth-1:0]   p_ff;
   logic signed [ProdWidth-1:0]   product;
   logic signed [MulWidth-1:0]    mul_a, mul_b;

   logic signed [COORD_WIDTH-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_WIDTH-1:0] ax_in, ay_in, bx_in, by_in;
   logic signed [MulWidth-1:0]    dx_ff, dy_ff, dx_in, dy_in;
   logic signed [ProdWidth-1:0]   cross_ff, cross_in;
   logic        [SqWidth-1:0]     sq_ff, sq_in;

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_WIDTH-1:0] first_x_in, first_y_in, prev_x_in, prev_y_in;
   logic signed [AreaWidth-1:0]   area_sum_ff, area_sum_in;
   logic        [PerimWidth-1:0]  perim_sum_ff, perim_sum_in;
   logic        [CountWidth-1:0]  count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic                          last_ff, last_in;
   logic                          closing_ff, closing_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [AreaWidth-1:0]   rsp_area_ff;
   logic        [PerimWidth-1:0]  rsp_perim_ff;
   logic        [SideWidth-1:0]   rsp_side_ff;
   logic                          rsp_ovf_ff;
   logic                          rsp_load;
   logic                          out_free;
   logic                          sums_clear;

   logic [COORD_WIDTH+VertexWidth-1:0] x_wide, y_wide;
   logic signed [COORD_WIDTH-1:0]      in_x, in_y;
   logic                               ld_edge;
   logic signed [COORD_WIDTH-1:0]      ld_ax, ld_ay, ld_bx, ld_by;

   logic                          sqrt_start;
   logic                          sqrt_done;
   logic [MulWidth-1:0]           sqrt_root;

   logic [AccWidth-1:0]           area_ext;
   logic [AreaWidth-1:0]          area_sat;
   logic [PsumWidth-1:0]          psum;
   logic [PerimWidth-1:0]         perim_sat;
   logic [CountWidth+SideWidth-1:0] side_wide;

   assign x_wide   = {{COORD_WIDTH{1'b0}}, req_chan.vertex_x};
   assign y_wide   = {{COORD_WIDTH{1'b0}}, req_chan.vertex_y};
   assign in_x     = x_wide[COORD_WIDTH-1:0];
   assign in_y     = y_wide[COORD_WIDTH-1:0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign side_wide = {{SideWidth{1'b0}}, count_ff};
   assign sums_clear = (count_ff == '0) && (area_sum_ff == '0) && (perim_sum_ff == '0) &&
                       !ovf_ff;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.area       = rsp_area_ff;
   assign rsp_chan.perimeter  = rsp_perim_ff;
   assign rsp_chan.side_count = rsp_side_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

   // shared multiplier
   always_comb begin
      case (step_ff)
         MUL_XY: begin
            mul_a = {ax_ff[COORD_WIDTH-1], ax_ff};
            mul_b = {by_ff[COORD_WIDTH-1], by_ff};
         end
         MUL_YX: begin
            mul_a = {ay_ff[COORD_WIDTH-1], ay_ff};
            mul_b = {bx_ff[COORD_WIDTH-1], bx_ff};
         end
         MUL_DXX: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         default: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
      endcase
      product = mul_a * mul_b;
   end

   // saturating accumulators
   always_comb begin
      area_ext = {{(AccWidth-AreaWidth){area_sum_ff[AreaWidth-1]}}, area_sum_ff}
               + {{(AccWidth-ProdWidth){cross_ff[ProdWidth-1]}}, cross_ff};
      if ((area_ext[AccWidth-1:AreaWidth-1] == '0) ||
          (area_ext[AccWidth-1:AreaWidth-1] == '1)) begin
         area_sat = area_ext[AreaWidth-1:0];
      end else if (area_ext[AccWidth-1]) begin
         area_sat = {1'b1, {(AreaWidth-1){1'b0}}};
      end else begin
         area_sat = {1'b0, {(AreaWidth-1){1'b1}}};
      end
      psum = {{(PsumWidth-PerimWidth){1'b0}}, perim_sum_ff}
           + {{(PsumWidth-MulWidth){1'b0}}, sqrt_root};
      if (psum[PsumWidth-1:PerimWidth] == '0) begin
         perim_sat = psum[PerimWidth-1:0];
      end else begin
         perim_sat = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      p_vld_in     = 1'b0;
      cross_in     = cross_ff;
      sq_in        = sq_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      area_sum_in  = area_sum_ff;
      perim_sum_in = perim_sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      closing_in   = closing_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_load     = 1'b0;
      sqrt_start   = 1'b0;
      ld_edge      = 1'b0;
      ld_ax        = in_x;
      ld_ay        = in_y;
      ld_bx        = prev_x_ff;
      ld_by        = prev_y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               prev_x_in = in_x;
               prev_y_in = in_y;
               last_in   = req_chan.is_last;
               if (count_ff < MaxCount) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (count_ff == '0) begin
                  first_x_in = in_x;
                  first_y_in = in_y;
                  if (req_chan.is_last) begin
                     ld_edge    = 1'b1;
                     ld_bx      = in_x;
                     ld_by      = in_y;
                     closing_in = 1'b1;
                     step_in    = MUL_XY;
                     state_in   = ST_MUL;
                  end
               end else begin
                  ld_edge    = 1'b1;
                  closing_in = 1'b0;
                  step_in    = MUL_XY;
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            p_vld_in = (step_ff != MUL_FLUSH);
            if (p_vld_ff) begin
               case (p_step_ff)
                  MUL_XY:  cross_in = p_ff;
                  MUL_YX:  cross_in = cross_ff - p_ff;
                  MUL_DXX: sq_in    = p_ff[SqWidth-1:0];
                  MUL_DYY: sq_in    = sq_ff + p_ff[SqWidth-1:0];
                  default: ;
               endcase
            end
            if (step_ff == MUL_FLUSH) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end else begin
               step_in = pap_step_type'(step_ff + 1'b1);
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            area_sum_in  = area_sat;
            perim_sum_in = perim_sat;
            if (last_ff && !closing_ff) begin
               ld_edge    = 1'b1;
               ld_ax      = first_x_ff;
               ld_ay      = first_y_ff;
               closing_in = 1'b1;
               step_in    = MUL_XY;
               state_in   = ST_MUL;
            end else if (last_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               area_sum_in  = '0;
               perim_sum_in = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               last_in      = 1'b0;
               closing_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ax_in = ax_ff;
      ay_in = ay_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (ld_edge) begin
         ax_in = ld_ax;
         ay_in = ld_ay;
         bx_in = ld_bx;
         by_in = ld_by;
         dx_in = {ld_ax[COORD_WIDTH-1], ld_ax} - {ld_bx[COORD_WIDTH-1], ld_bx};
         dy_in = {ld_ay[COORD_WIDTH-1], ld_ay} - {ld_by[COORD_WIDTH-1], ld_by};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= MUL_XY;
         p_vld_ff     <= 1'b0;
         area_sum_ff  <= '0;
         perim_sum_ff <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         p_vld_ff     <= p_vld_in;
         area_sum_ff  <= area_sum_in;
         perim_sum_ff <= perim_sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         closing_ff   <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= product;
      p_step_ff  <= step_ff;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      cross_ff   <= cross_in;
      sq_ff      <= sq_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      if (rsp_load) begin
         rsp_area_ff  <= area_sum_ff;
         rsp_perim_ff <= perim_sum_ff;
         rsp_side_ff  <= side_wide[SideWidth-1:0];
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   pap_sqrt #(
      .ROOT_WIDTH (MulWidth)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({1'b0, sq_in}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   `PAP_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff <= MaxCount, "count past limit")
   `PAP_ASSERT(a_ovf_at_limit, clock, reset, ovf_ff, count_ff == MaxCount, "overflow below limit")
   `PAP_ASSERT_NEXT(a_clear_after_result, clock, reset, rsp_load, sums_clear, "state not cleared")
   `PAP_ASSERT(a_root_in_sqrt, clock, reset, sqrt_done, state_ff == ST_SQRT, "root out of phase")
   `PAP_ASSERT(a_closing_last, clock, reset, closing_ff && state_ff != ST_IDLE, last_ff, "no last")

endmodule
